// ----- rtl/core/srwb_pkg.sv -----
package srwb_pkg;

  localparam int MAX_SLOTS = 64;
  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int PAYLOAD_BYTES = 1024;
  localparam int OFF_W = $clog2(PAYLOAD_BYTES);
  localparam int PAY_AW = SLOT_W + OFF_W;
  localparam int SIZE_W = 7;
  localparam int LEN_W = 11;
  localparam int SEQ_W = 32;
  localparam int CNT_W = $clog2(SEQ_W);

  localparam logic [2:0] REQ_INIT   = 3'd0;
  localparam logic [2:0] REQ_ADD    = 3'd1;
  localparam logic [2:0] REQ_READ   = 3'd2;
  localparam logic [2:0] REQ_REMOVE = 3'd3;
  localparam logic [2:0] REQ_SLIDE  = 3'd4;
  localparam logic [2:0] REQ_SETCUR = 3'd5;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd8;

endpackage

// ----- rtl/core/srwb_ram.sv -----
module srwb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/core/srwb_mod.sv -----
module srwb_mod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [srwb_pkg::SEQ_W-1:0]  dividend,
  input  logic [srwb_pkg::SIZE_W-1:0] divisor,
  output logic                        done,
  output logic [srwb_pkg::SLOT_W-1:0] rem_out
);
  import srwb_pkg::*;

  logic [SEQ_W-1:0]  sh;
  logic [SIZE_W-1:0] rem;
  logic [CNT_W-1:0]  cnt;
  logic              run;
  logic [SIZE_W-1:0] trial;
  logic [SIZE_W-1:0] rem_next;

  always_comb begin
    trial = {rem[SIZE_W-2:0], sh[SEQ_W-1]};
    rem_next = (trial >= divisor) ? trial - divisor : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        sh <= dividend;
        rem <= '0;
        cnt <= '0;
      end else if (run) begin
        rem <= rem_next;
        sh <= {sh[SEQ_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(SEQ_W - 1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem_out = rem[SLOT_W-1:0];
endmodule

// ----- rtl/core/selective_repeat_window_buffer.sv -----
// Selective-repeat window store. A request is taken when start is high and busy
// is low; its single result appears with done for one cycle and cannot be held
// off. Each request first passes through the serial remainder unit that maps a
// sequence number to its slot, then through the write, read and report states.
// A slide that advances the bottom runs the remainder unit a second time and
// then clears one slot per cycle, up to the window size, before the write, read
// and report states. Changing window_size takes effect on the next request.
module selective_repeat_window_buffer (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type,
  input  logic [31:0] seq_num,
  input  logic [9:0]  byte_offset,
  input  logic [7:0]  data_byte,
  input  logic [10:0] payload_len,
  input  logic        last_byte,
  output logic        done,
  output logic [7:0]  data_byte_out,
  output logic [10:0] entry_len,
  output logic        entry_valid,
  output logic        window_full,
  output logic        all_clear,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import srwb_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV1 = 3'd1;
  localparam logic [2:0] ST_DIV2 = 3'd2;
  localparam logic [2:0] ST_CLR  = 3'd3;
  localparam logic [2:0] ST_EXEC = 3'd4;
  localparam logic [2:0] ST_RD   = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]           state;
  logic [SIZE_W-1:0]    window_size;
  logic [SIZE_W-1:0]    eff;
  logic [SIZE_W-1:0]    size;
  logic [2:0]           req;
  logic [SEQ_W-1:0]     seq;
  logic [OFF_W-1:0]     off;
  logic [7:0]           dbyte;
  logic [LEN_W-1:0]     dlen;
  logic                 last;
  logic [SLOT_W-1:0]    slot;
  logic [SLOT_W-1:0]    sslot;
  logic [SIZE_W-1:0]    ncl;
  logic [MAX_SLOTS-1:0] valid;
  logic [MAX_SLOTS-1:0] len_ok;
  logic [SIZE_W-1:0]    valid_count;
  logic [SEQ_W-1:0]     bottom;
  logic [SEQ_W:0]       top;
  logic [SEQ_W-1:0]     current;
  logic                 div_go;
  logic                 div_done;
  logic [SLOT_W-1:0]    div_rem;
  logic [SEQ_W-1:0]     div_in;
  logic [SEQ_W-1:0]     diff;
  logic                 len_we;
  logic [LEN_W-1:0]     len_wdata;
  logic [LEN_W-1:0]     len_rdata;
  logic                 pay_we;
  logic [7:0]           pay_rdata;
  logic                 need_slide;

  always_comb begin
    if (window_size == '0) begin
      eff = SIZE_W'(1);
    end else if (window_size > SIZE_W'(MAX_SLOTS)) begin
      eff = SIZE_W'(MAX_SLOTS);
    end else begin
      eff = window_size;
    end
  end

  assign busy = (state != ST_IDLE);
  assign pready = 1'b1;
  assign prdata = {{(32 - SIZE_W){1'b0}}, window_size};

  assign need_slide = (req == REQ_SLIDE) && (seq > bottom);
  assign diff = seq - bottom;
  assign div_go = ((state == ST_IDLE) && start) ||
                  ((state == ST_DIV1) && div_done && need_slide);
  assign div_in = (state == ST_IDLE) ? seq_num - 1'b1 : bottom - 1'b1;

  srwb_mod u_mod (
    .clk(clk),
    .rst(rst),
    .go(div_go),
    .dividend(div_in),
    .divisor((state == ST_IDLE) ? eff : size),
    .done(div_done),
    .rem_out(div_rem)
  );

  assign len_we = (state == ST_EXEC) && (req == REQ_ADD) && last;
  assign len_wdata = (dlen > LEN_W'(PAYLOAD_BYTES)) ? LEN_W'(PAYLOAD_BYTES) : dlen;
  assign pay_we = (state == ST_EXEC) && (req == REQ_ADD);

  srwb_ram #(.WIDTH(LEN_W), .DEPTH(MAX_SLOTS)) u_len (
    .clk(clk),
    .we(len_we),
    .waddr(slot),
    .wdata(len_wdata),
    .raddr(slot),
    .rdata(len_rdata)
  );

  srwb_ram #(.WIDTH(8), .DEPTH(MAX_SLOTS * PAYLOAD_BYTES)) u_pay (
    .clk(clk),
    .we(pay_we),
    .waddr({slot, off}),
    .wdata(dbyte),
    .raddr({slot, off}),
    .rdata(pay_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= SIZE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      window_size <= pwdata[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done <= 1'b0;
      valid <= '0;
      len_ok <= '0;
      valid_count <= '0;
      bottom <= SEQ_W'(1);
      current <= SEQ_W'(1);
      top <= (SEQ_W + 1)'(SIZE_RESET);
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            req <= req_type;
            seq <= seq_num;
            off <= byte_offset;
            dbyte <= data_byte;
            dlen <= payload_len;
            last <= last_byte;
            size <= eff;
            state <= ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (div_done) begin
            slot <= div_rem;
            ncl <= (diff > SEQ_W'(size)) ? size : diff[SIZE_W-1:0];
            state <= need_slide ? ST_DIV2 : ST_EXEC;
          end
        end
        ST_DIV2: begin
          if (div_done) begin
            sslot <= div_rem;
            state <= ST_CLR;
          end
        end
        ST_CLR: begin
          if (ncl == '0) begin
            state <= ST_EXEC;
          end else begin
            if (valid[sslot]) begin
              valid[sslot] <= 1'b0;
              valid_count <= valid_count - 1'b1;
            end
            sslot <= ({1'b0, sslot} + 1'b1 >= size) ? '0 : sslot + 1'b1;
            ncl <= ncl - 1'b1;
          end
        end
        ST_EXEC: begin
          case (req)
            REQ_INIT: begin
              valid <= '0;
              len_ok <= '0;
              valid_count <= '0;
              bottom <= SEQ_W'(1);
              current <= SEQ_W'(1);
              top <= (SEQ_W + 1)'(size);
            end
            REQ_ADD: begin
              if (last) begin
                len_ok[slot] <= 1'b1;
                if (!valid[slot]) begin
                  valid[slot] <= 1'b1;
                  valid_count <= valid_count + 1'b1;
                end
              end
            end
            REQ_REMOVE: begin
              if (valid[slot]) begin
                valid[slot] <= 1'b0;
                valid_count <= valid_count - 1'b1;
              end
            end
            REQ_SLIDE: begin
              bottom <= seq;
              top <= {1'b0, seq} + (SEQ_W + 1)'(size) - 1'b1;
            end
            REQ_SETCUR: begin
              current <= seq;
            end
            default: begin
            end
          endcase
          state <= ST_RD;
        end
        ST_RD: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          done <= 1'b1;
          data_byte_out <= (req == REQ_READ) ? pay_rdata : 8'd0;
          entry_len <= len_ok[slot] ? len_rdata : '0;
          entry_valid <= valid[slot];
          window_full <= ({1'b0, current} > top);
          all_clear <= (valid_count == '0);
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end
endmodule
